// ===== src/imm_pkg.sv =====
// Shared types and constants for the integer matrix multiply block.
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

    // Fixed field widths
    localparam int DATA_W = 64;
    localparam int IDX_W  = 3;
    localparam int DIM_W  = 4;
    localparam int CMD_W  = 2;
    localparam int CFG_W  = 2;
    localparam int TDATA_W = 72;

    // Command codes carried in s_tuser
    localparam logic [CMD_W-1:0] CMD_WR_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MUL  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_W-1:0] REG_COLS_B    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // Tag that travels with each read pair through the MAC pipeline
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } tag_t;

endpackage

`default_nettype wire

// ===== src/imm_mem.sv =====
// Single-port-write, single-port-read synchronous element store.
`timescale 1ns / 1ps
`default_nettype none

module imm_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire                            aclk,
    input  wire                            wr_en,
    input  wire [AW-1:0]                   wr_addr,
    input  wire [imm_pkg::DATA_W-1:0]      wr_data,
    input  wire [AW-1:0]                   rd_addr,
    output logic [imm_pkg::DATA_W-1:0]     rd_data
);

    logic [imm_pkg::DATA_W-1:0] mem [DEPTH];
    logic [imm_pkg::DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/imm_mac.sv =====
// Pipelined 64-bit wrapping multiply-accumulate built from 32-bit partial products.
`timescale 1ns / 1ps
`default_nettype none

module imm_mac (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire [imm_pkg::DATA_W-1:0]      a_data,
    input  wire [imm_pkg::DATA_W-1:0]      b_data,
    input  imm_pkg::tag_t                  in_tag,
    output logic [imm_pkg::DATA_W-1:0]     acc,
    output logic                           done
);

    logic [63:0]   ll_reg, ll_next;
    logic [31:0]   lh_reg, lh_next;
    logic [31:0]   hl_reg, hl_next;
    logic [63:0]   prod_reg, prod_next;
    logic [63:0]   acc_reg, acc_next;
    logic          done_reg, done_next;
    imm_pkg::tag_t tag1_reg, tag2_reg;

    // Stage 1: partial products; only the low 64 bits of the full product matter
    assign ll_next = {32'b0, a_data[31:0]} * {32'b0, b_data[31:0]};
    assign lh_next = a_data[31:0] * b_data[63:32];
    assign hl_next = a_data[63:32] * b_data[31:0];

    // Stage 2: combine partials
    assign prod_next = ll_reg + {lh_reg + hl_reg, 32'b0};

    // Stage 3: accumulate, restart on the first term of an element
    assign acc_next  = tag2_reg.first ? prod_reg : acc_reg + prod_reg;
    assign done_next = tag2_reg.vld & tag2_reg.last;

    always_ff @(posedge aclk) begin
        ll_reg   <= ll_next;
        lh_reg   <= lh_next;
        hl_reg   <= hl_next;
        prod_reg <= prod_next;
        if (tag2_reg.vld) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            done_reg <= done_next;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== src/integer_matrix_multiply.sv =====
// Integer matrix multiply C = A x B: sequencer, element stores, MAC and output register.
// Element write items do not leave the idle state, so the block stays ready for the next item.
// A multiply item walks every result element in turn: store reads of the inner terms,
// a drain of the MAC pipeline, then a load of the output register, which waits on a stall.
// The dot product rate is set by the single read port of each store (one term per cycle).
// Reset (aresetn low, synchronous) sets all dimensions to 8 and clears control state;
// store contents are undefined until written and there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module integer_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // Configuration write channel
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [imm_pkg::CFG_W-1:0]           cfg_index,
    input  wire [imm_pkg::DIM_W-1:0]           cfg_data,
    // Input items
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [imm_pkg::TDATA_W-1:0]         s_tdata,  // row[2:0], col[5:3], value[69:6]
    input  wire [imm_pkg::CMD_W-1:0]           s_tuser,  // command[1:0]
    // Result items
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [imm_pkg::TDATA_W-1:0]        m_tdata,  // out_row[2:0], out_col[5:3],
                                                         // product_value[69:6]
    output logic                               m_tlast   // last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [6:0] MAX_W = 7'(MAX_DIM);
    localparam logic [imm_pkg::DIM_W-1:0] DIM_MAX = (MAX_DIM > 15) ? 4'd15 : 4'(MAX_DIM);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [imm_pkg::DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [imm_pkg::DIM_W-1:0] nr, nk, nc;
    logic [1:0]                state_reg, state_next;
    logic [imm_pkg::DIM_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    imm_pkg::tag_t             rd_tag_reg, rd_tag_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [imm_pkg::IDX_W-1:0]   out_row_reg, out_col_reg;
    logic [imm_pkg::DATA_W-1:0]  out_val_reg;
    logic                        out_last_reg;
    logic                        out_load, last_elem, last_col, last_k;

    logic [imm_pkg::CMD_W-1:0]   in_cmd;
    logic [imm_pkg::IDX_W-1:0]   in_row, in_col;
    logic [imm_pkg::DATA_W-1:0]  in_value;
    logic                        in_accept, in_range, we_a, we_b;
    logic [AW-1:0]               wr_addr, a_raddr, b_raddr;
    logic [imm_pkg::DATA_W-1:0]  a_rdata, b_rdata, mac_acc;
    logic                        mac_done;

    function automatic logic [imm_pkg::DIM_W-1:0] clamp_dim(
        input logic [imm_pkg::DIM_W-1:0] v
    );
        logic [imm_pkg::DIM_W-1:0] r;
        if (v == '0) begin
            r = 4'd1;
        end else if ({3'b0, v} > MAX_W) begin
            r = DIM_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Input item fields
    assign in_cmd   = s_tuser;
    assign in_row   = s_tdata[2:0];
    assign in_col   = s_tdata[5:3];
    assign in_value = s_tdata[69:6];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg    <= imm_pkg::DIM_RESET;
            inner_dim_reg <= imm_pkg::DIM_RESET;
            cols_b_reg    <= imm_pkg::DIM_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                imm_pkg::REG_ROWS_A:    rows_a_reg    <= cfg_data;
                imm_pkg::REG_INNER_DIM: inner_dim_reg <= cfg_data;
                imm_pkg::REG_COLS_B:    cols_b_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign nr = clamp_dim(rows_a_reg);
    assign nk = clamp_dim(inner_dim_reg);
    assign nc = clamp_dim(cols_b_reg);

    // Element writes: indexes beyond the store are dropped
    assign in_range = ({4'b0, in_row} < MAX_W) && ({4'b0, in_col} < MAX_W);
    assign we_a     = in_accept && (in_cmd == imm_pkg::CMD_WR_A) && in_range;
    assign we_b     = in_accept && (in_cmd == imm_pkg::CMD_WR_B) && in_range;
    assign wr_addr  = AW'(in_row) * AW'(MAX_DIM) + AW'(in_col);

    // Read addresses: A[i][k] and B[k][j]
    assign a_raddr = AW'(i_reg) * AW'(MAX_DIM) + AW'(k_reg);
    assign b_raddr = AW'(k_reg) * AW'(MAX_DIM) + AW'(j_reg);

    imm_mem #(.DEPTH(DEPTH), .AW(AW)) u_a_mem (
        .aclk    (aclk),
        .wr_en   (we_a),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_addr (a_raddr),
        .rd_data (a_rdata)
    );

    imm_mem #(.DEPTH(DEPTH), .AW(AW)) u_b_mem (
        .aclk    (aclk),
        .wr_en   (we_b),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_addr (b_raddr),
        .rd_data (b_rdata)
    );

    imm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .a_data  (a_rdata),
        .b_data  (b_rdata),
        .in_tag  (rd_tag_reg),
        .acc     (mac_acc),
        .done    (mac_done)
    );

    assign last_k    = (k_reg == nk - 4'd1);
    assign last_col  = (j_reg == nc - 4'd1);
    assign last_elem = last_col && (i_reg == nr - 4'd1);
    assign out_load  = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    // Sequencer: read terms, drain the MAC, load the output register, step i/j
    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        rd_tag_next   = '0;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && (in_cmd == imm_pkg::CMD_MUL)) begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                rd_tag_next.vld   = 1'b1;
                rd_tag_next.first = (k_reg == '0);
                rd_tag_next.last  = last_k;
                if (last_k) begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end else begin
                    k_next = k_reg + 4'd1;
                end
            end
            ST_WAIT: begin
                if (mac_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    if (last_elem) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_READ;
                        if (last_col) begin
                            j_next = '0;
                            i_next = i_reg + 4'd1;
                        end else begin
                            j_next = j_reg + 4'd1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            rd_tag_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            rd_tag_reg   <= rd_tag_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_row_reg  <= i_reg[imm_pkg::IDX_W-1:0];
            out_col_reg  <= j_reg[imm_pkg::IDX_W-1:0];
            out_val_reg  <= mac_acc;
            out_last_reg <= last_elem;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b0, out_val_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;

    // The MAC finishes an element only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> (state_reg == ST_WAIT))
        else $error("MAC result arrived outside the wait state");

    // Stores are written only between multiply runs
    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (we_a || we_b) |-> (state_reg == ST_IDLE))
        else $error("store write during a multiply run");

    // A blocked output keeps the sequencer parked in the emit state
    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && m_tvalid_reg && !m_tready) |=> (state_reg == ST_EMIT))
        else $error("emit state left while output register was full");

    // The final element returns the block to idle with a marked result pending
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last_elem) |=> (state_reg == ST_IDLE && m_tvalid_reg && out_last_reg))
        else $error("last element did not close the run");

endmodule

`default_nettype wire

// ===== tb/integer_matrix_multiply_checker.sv =====
// Checker for the integer matrix multiply: tracks stores and dimensions, predicts and compares.
`timescale 1ns / 1ps

module integer_matrix_multiply_checker (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_valid,
    input  wire                                 cfg_ready,
    input  wire [imm_pkg::CFG_W-1:0]            cfg_index,
    input  wire [imm_pkg::DIM_W-1:0]            cfg_data,
    input  wire                                 s_tvalid,
    input  wire                                 s_tready,
    input  wire [imm_pkg::TDATA_W-1:0]          s_tdata,   // row[2:0], col[5:3], value[69:6]
    input  wire [imm_pkg::CMD_W-1:0]            s_tuser,   // command[1:0]
    input  wire                                 m_tvalid,
    input  wire                                 m_tready,
    input  wire [imm_pkg::TDATA_W-1:0]          m_tdata,   // out_row[2:0], out_col[5:3],
                                                           // product_value[69:6]
    input  wire                                 m_tlast,   // last
    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  results_checked,
    output int                                  multiplies
);

    localparam int MAX_DIM = 8;

    typedef struct packed {
        logic [imm_pkg::IDX_W-1:0]  row;
        logic [imm_pkg::IDX_W-1:0]  col;
        logic [imm_pkg::DATA_W-1:0] value;
        logic                       last;
    } element_t;

    // Shadow copies of the element stores, addressed {row, col}
    logic [imm_pkg::DATA_W-1:0] a_elems [0:MAX_DIM*MAX_DIM-1];
    logic [imm_pkg::DATA_W-1:0] b_elems [0:MAX_DIM*MAX_DIM-1];
    logic [imm_pkg::DIM_W-1:0]  rows_reg, inner_reg, cols_reg;
    element_t                   product_q [$];

    initial begin
        mismatches      = 0;
        outstanding     = 0;
        results_checked = 0;
        multiplies      = 0;
    end

    // Zero saturates to one, anything above the store size saturates to it
    function automatic int dim_in_use(input logic [imm_pkg::DIM_W-1:0] d);
        if (d == '0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return int'(d);
    endfunction

    // Walk the result in row-major order and queue every dot product
    task automatic predict_products();
        int nr, nk, nc;
        logic [imm_pkg::DATA_W-1:0] acc;
        element_t e;
        nr = dim_in_use(rows_reg);
        nk = dim_in_use(inner_reg);
        nc = dim_in_use(cols_reg);
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                acc = '0;
                for (int k = 0; k < nk; k++)
                    acc += a_elems[i*MAX_DIM + k] * b_elems[k*MAX_DIM + j];
                e.row   = i[imm_pkg::IDX_W-1:0];
                e.col   = j[imm_pkg::IDX_W-1:0];
                e.value = acc;
                e.last  = (i == nr - 1) && (j == nc - 1);
                product_q.push_back(e);
            end
        end
    endtask

    always @(posedge aclk) begin
        element_t exp_e;
        int       errs;
        if (!aresetn) begin
            rows_reg  <= imm_pkg::DIM_RESET;
            inner_reg <= imm_pkg::DIM_RESET;
            cols_reg  <= imm_pkg::DIM_RESET;
            product_q.delete();
            outstanding <= 0;
        end else begin
            errs = 0;
            // Results first, so an item in the same cycle cannot satisfy itself
            if (m_tvalid && m_tready) begin
                if (product_q.size() == 0) begin
                    $display("%0t: result item expected none, actual row=%0d col=%0d %s",
                             $time, m_tdata[2:0], m_tdata[5:3],
                             $sformatf("value=%0d last=%0b", $signed(m_tdata[69:6]),
                                       m_tlast));
                    errs++;
                end else begin
                    exp_e = product_q.pop_front();
                    if (m_tdata[2:0] !== exp_e.row) begin
                        $display("%0t: out_row expected %0d actual %0d",
                                 $time, exp_e.row, m_tdata[2:0]);
                        errs++;
                    end
                    if (m_tdata[5:3] !== exp_e.col) begin
                        $display("%0t: out_col expected %0d actual %0d",
                                 $time, exp_e.col, m_tdata[5:3]);
                        errs++;
                    end
                    if (m_tdata[69:6] !== exp_e.value) begin
                        $display("%0t: product_value at (%0d,%0d) expected %0d actual %0d",
                                 $time, exp_e.row, exp_e.col, $signed(exp_e.value),
                                 $signed(m_tdata[69:6]));
                        errs++;
                    end
                    if (m_tlast !== exp_e.last) begin
                        $display("%0t: last at (%0d,%0d) expected %0b actual %0b",
                                 $time, exp_e.row, exp_e.col, exp_e.last, m_tlast);
                        errs++;
                    end
                end
                results_checked <= results_checked + 1;
            end

            // Register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    imm_pkg::REG_ROWS_A:    rows_reg  <= cfg_data;
                    imm_pkg::REG_INNER_DIM: inner_reg <= cfg_data;
                    imm_pkg::REG_COLS_B:    cols_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // Input items: element writes or a multiply
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    imm_pkg::CMD_WR_A: a_elems[{s_tdata[2:0], s_tdata[5:3]}] = s_tdata[69:6];
                    imm_pkg::CMD_WR_B: b_elems[{s_tdata[2:0], s_tdata[5:3]}] = s_tdata[69:6];
                    imm_pkg::CMD_MUL: begin
                        predict_products();
                        multiplies <= multiplies + 1;
                    end
                    default: ;
                endcase
            end

            mismatches  <= mismatches + errs;
            outstanding <= product_q.size();
        end
    end

endmodule

// ===== tb/integer_matrix_multiply_tb.sv =====
// Testbench top for the integer matrix multiply: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module integer_matrix_multiply_tb;

    localparam int IDX_W = imm_pkg::IDX_W;
    localparam int DIM_W = imm_pkg::DIM_W;
    localparam int ITEM_TARGET = 370;
    localparam logic [imm_pkg::CMD_W-1:0] CMD_NOP    = 2'd3;   // unused command, ignored
    localparam logic [imm_pkg::CFG_W-1:0] REG_UNUSED = 2'd3;   // no register behind this index

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        cfg_valid;
    wire                         cfg_ready;
    logic [imm_pkg::CFG_W-1:0]   cfg_index;
    logic [DIM_W-1:0]            cfg_data;
    logic                        s_tvalid;
    wire                         s_tready;
    logic [imm_pkg::TDATA_W-1:0] s_tdata;
    logic [imm_pkg::CMD_W-1:0]   s_tuser;
    wire                         m_tvalid;
    logic                        m_tready = 1'b0;
    wire  [imm_pkg::TDATA_W-1:0] m_tdata;
    wire                         m_tlast;

    int mismatches, outstanding, results_checked, multiplies;
    int sent = 0;
    int settings = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int cur_rows = 8, cur_inner = 8, cur_cols = 8;

    always #6 aclk = ~aclk;

    integer_matrix_multiply dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    integer_matrix_multiply_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .multiplies      (multiplies)
    );

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Hard stop
    initial begin
        #60_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int clip_dim(input logic [DIM_W-1:0] d);
        if (d == '0)
            return 1;
        if (d > 8)
            return 8;
        return int'(d);
    endfunction

    // Element values: extremes, small numbers, full-width random
    function automatic logic [imm_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return '1;
            3: return '0;
            4: return 64'(signed'(int'($urandom_range(31)) - 16));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly small dimensions, sometimes the full size or a saturating value
    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return DIM_W'($urandom_range(1, 3));
        if (r < 80)
            return DIM_W'($urandom_range(4, 8));
        if (r < 86)
            return DIM_W'(8);
        if (r < 93)
            return '0;
        return DIM_W'($urandom_range(9, 15));
    endfunction

    task automatic send_item(input logic [imm_pkg::CMD_W-1:0] cmd,
                             input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                             input logic [imm_pkg::DATA_W-1:0] v);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {2'b00, v, c, r};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (cmd != CMD_NOP)
            sent++;
    endtask

    task automatic write_reg(input logic [imm_pkg::CFG_W-1:0] idx,
                             input logic [DIM_W-1:0] d);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] k,
                            input logic [DIM_W-1:0] c);
        write_reg(imm_pkg::REG_ROWS_A, r);
        write_reg(imm_pkg::REG_INNER_DIM, k);
        write_reg(imm_pkg::REG_COLS_B, c);
        cur_rows  = clip_dim(r);
        cur_inner = clip_dim(k);
        cur_cols  = clip_dim(c);
        settings++;
    endtask

    // Hold the sender until every queued result has come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
    endtask

    // Drain, then give the MAC pipeline time to empty before touching registers
    task automatic settle();
        drain();
        repeat (16) @(negedge aclk);
    endtask

    // Random element write, usually inside the dimensions in use
    task automatic random_write();
        logic [imm_pkg::CMD_W-1:0] cmd;
        int nr, nc;
        cmd = $urandom_range(1) ? imm_pkg::CMD_WR_B : imm_pkg::CMD_WR_A;
        nr  = (cmd == imm_pkg::CMD_WR_A) ? cur_rows : cur_inner;
        nc  = (cmd == imm_pkg::CMD_WR_A) ? cur_inner : cur_cols;
        if ($urandom_range(3) != 0)
            send_item(cmd, IDX_W'($urandom_range(nr - 1)), IDX_W'($urandom_range(nc - 1)),
                      pick_value());
        else
            send_item(cmd, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
                      pick_value());
    endtask

    initial begin
        int phase;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        send_idle = 13;
        recv_idle = 51;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Fill both stores so no multiply ever reads an unwritten element,
        // then multiply at the reset dimensions
        for (int i = 0; i < 64; i++) begin
            send_item(imm_pkg::CMD_WR_A, IDX_W'(i / 8), IDX_W'(i % 8), pick_value());
            send_item(imm_pkg::CMD_WR_B, IDX_W'(i / 8), IDX_W'(i % 8), pick_value());
        end
        send_item(imm_pkg::CMD_MUL, '0, '0, '0);

        // Directed: 1x1x1 with wrapping extremes
        settle();
        set_dims(4'd1, 4'd1, 4'd1);
        send_item(imm_pkg::CMD_WR_A, 3'd0, 3'd0, 64'h8000_0000_0000_0000);
        send_item(imm_pkg::CMD_WR_B, 3'd0, 3'd0, '1);
        send_item(imm_pkg::CMD_MUL, 3'd7, 3'd7, '1);
        send_item(imm_pkg::CMD_WR_A, 3'd0, 3'd0, 64'h7fff_ffff_ffff_ffff);
        send_item(imm_pkg::CMD_WR_B, 3'd0, 3'd0, 64'h7fff_ffff_ffff_ffff);
        send_item(imm_pkg::CMD_MUL, '0, '0, '0);
        // Unused command must leave the stores alone
        send_item(CMD_NOP, 3'd0, 3'd0, '0);
        // Write outside the configured dimensions is stored but unused here
        send_item(imm_pkg::CMD_WR_A, 3'd7, 3'd7, 64'h8000_0000_0000_0000);
        send_item(imm_pkg::CMD_WR_B, 3'd7, 3'd7, '1);
        send_item(imm_pkg::CMD_MUL, '0, '0, '0);

        // Saturating register values: zero and above the store size
        settle();
        set_dims(4'd0, 4'd15, 4'd0);
        send_item(imm_pkg::CMD_MUL, '0, '0, '0);
        settle();
        write_reg(REG_UNUSED, 4'hf);
        set_dims(4'd15, 4'd0, 4'd15);
        send_item(imm_pkg::CMD_MUL, '0, '0, '0);
        settle();
        set_dims(4'd2, 4'd3, 4'd4);
        send_item(imm_pkg::CMD_WR_A, 3'd1, 3'd2, 64'h7fff_ffff_ffff_ffff);
        send_item(imm_pkg::CMD_WR_B, 3'd2, 3'd3, 64'h7fff_ffff_ffff_ffff);
        send_item(imm_pkg::CMD_MUL, '0, '0, '0);

        // Random segments: new dimensions, then write bursts each closed by a multiply
        while (sent < ITEM_TARGET) begin
            settle();
            phase = sent * 3 / ITEM_TARGET;
            case (phase)
                0: begin
                    send_idle = 13;
                    recv_idle = 51;
                end
                1: begin
                    send_idle = 51;
                    recv_idle = 13;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            if ($urandom_range(9) == 0)
                write_reg(REG_UNUSED, DIM_W'($urandom_range(15)));
            set_dims(pick_dim(), pick_dim(), pick_dim());
            repeat ($urandom_range(2, 5)) begin
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(9) == 0)
                        send_item(CMD_NOP, IDX_W'($urandom_range(7)),
                                  IDX_W'($urandom_range(7)), pick_value());
                    else
                        random_write();
                end
                if ($urandom_range(5) == 0)
                    drain();
                send_item(imm_pkg::CMD_MUL, IDX_W'($urandom_range(7)),
                          IDX_W'($urandom_range(7)), pick_value());
            end
        end

        settle();
        $display("Run covered %0d items, %0d multiplies over %0d dimension settings,",
                 sent, multiplies, settings);
        $display("and %0d result items compared field by field.", results_checked);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
